### rtl/ptwa_pkg.sv
// Package for the peer table with aging: sizes, codes and the request,
// response, entry and configuration types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ptwa_pkg;

	localparam int unsigned MAX_ENTRIES = 16;
	localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int unsigned ENTRY_W = 4;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned PADDR_W = 3;

	localparam logic [31:0] STALE_TIMEOUT_RESET = 32'd60000;

	typedef enum logic {
		OP_RECEIVE = 1'b0,
		OP_SWEEP   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_UPDATED = 3'd0,
		ST_ADDED   = 3'd1,
		ST_OWN     = 3'd2,
		ST_FULL    = 3'd3,
		ST_SWEEP   = 3'd4
	} status_t;

	typedef enum logic {
		REG_OWN_NODE_ID = 1'b0,
		REG_STALE_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} fsm_t;

	typedef struct packed {
		logic        op;
		logic [47:0] sender_address;
		logic [7:0]  sender_node;
		logic        is_heartbeat;
		logic [15:0] battery_mv;
		logic [7:0]  threat_level;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [ENTRY_W-1:0]   entry_index;
		logic [COUNT_W-1:0]   active_count;
		logic [COUNT_W-1:0]   filled_count;
		logic [COUNT_W-1:0]   expired_count;
	} rsp_t;

	typedef struct packed {
		logic [47:0] address;
		logic [31:0] seen_ms;
		logic        active;
		logic [7:0]  node;
		logic [15:0] battery_mv;
		logic [7:0]  threat_level;
	} entry_t;

	typedef struct packed {
		logic [7:0]  own_node_id;
		logic [31:0] stale_timeout_ms;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/ptwa_if.sv
// Request and response channel interfaces with valid/ready handshake.
// Depends on ptwa_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface ptwa_req_if;
	import ptwa_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ptwa_rsp_if;
	import ptwa_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/peer_table_with_aging.sv
// Peer table with aging: learns senders by 48-bit address and ages them out.
// A request walks the filled entries, stopping early at a match (an own-id request
// skips the walk), before its response is registered. No new request is taken
// until the previous one is done; the walk reads one entry per cycle over the
// single read port of the entry RAM, and a waiting response holds the next one
// back. Reset clears the counts and the control state, not the entry RAM.
`timescale 1ns / 1ps
`default_nettype none

module peer_table_with_aging (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [ptwa_pkg::PADDR_W-1:0]  paddr,
	input  wire  [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	ptwa_req_if.sink                      req,
	ptwa_rsp_if.source                    rsp
);
	import ptwa_pkg::*;

	cfg_t cfg;

	ptwa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ptwa_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

### rtl/ptwa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ptwa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                                          clk,
	input  wire                                          we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                             wdata,
	input  wire                                          re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/ptwa_cfg.sv
// APB-style register file for the own node id and the stale timeout.
// Depends on ptwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptwa_cfg (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [ptwa_pkg::PADDR_W-1:0]   paddr,
	input  wire  [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output ptwa_pkg::cfg_t                 cfg
);
	import ptwa_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr;

	assign sel    = reg_idx_t'(paddr[2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_node_id      <= '0;
			cfg_q.stale_timeout_ms <= STALE_TIMEOUT_RESET;
		end else if (wr) begin
			unique case (sel)
				REG_OWN_NODE_ID:   cfg_q.own_node_id      <= pwdata[7:0];
				REG_STALE_TIMEOUT: cfg_q.stale_timeout_ms <= pwdata;
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_OWN_NODE_ID:   prdata = {24'd0, cfg_q.own_node_id};
			REG_STALE_TIMEOUT: prdata = cfg_q.stale_timeout_ms;
			default:           prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/ptwa_engine.sv
// Lookup, learning and aging sequencer around the entry RAM.
// Depends on ptwa_pkg, ptwa_if and ptwa_ram.
`timescale 1ns / 1ps
`default_nettype none

module ptwa_engine (
	input  wire             clk,
	input  wire             arst_n,
	input  ptwa_pkg::cfg_t  cfg,
	ptwa_req_if.sink        req,
	ptwa_rsp_if.source      rsp
);
	import ptwa_pkg::*;

	fsm_t             state_q, state_nxt;
	req_t             req_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] total_q, total_nxt;
	logic [CNT_W-1:0] active_q, active_nxt;
	logic [CNT_W-1:0] expired_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t           hit_entry_q;
	logic             out_valid_q;
	rsp_t             out_q, out_nxt;

	entry_t           rd_data;
	entry_t           wr_data;
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             accept, own_in, own_fin, full;
	logic             scan_hit, scan_done, expire, fin_go;
	logic [31:0]      age;

	ptwa_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	assign accept    = req.valid && req.ready;
	assign own_in    = (req.data.op == OP_RECEIVE) && (req.data.sender_node == cfg.own_node_id);
	assign own_fin   = (req_q.op == OP_RECEIVE) && (req_q.sender_node == cfg.own_node_id);
	assign full      = (total_q == CNT_W'(MAX_ENTRIES));
	assign age       = req_q.now_ms - rd_data.seen_ms;
	assign scan_hit  = (state_q == FSM_SCAN) && valid_s1 && (req_q.op == OP_RECEIVE)
		&& (rd_data.address == req_q.sender_address);
	assign expire    = (state_q == FSM_SCAN) && valid_s1 && (req_q.op == OP_SWEEP)
		&& rd_data.active && (age > cfg.stale_timeout_ms);
	assign scan_done = !valid_s1 && (rd_idx_q == total_q);
	assign fin_go    = (state_q == FSM_FINISH) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (req.valid) begin
					state_nxt = own_in ? FSM_FINISH : FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (scan_hit || scan_done) begin
					state_nxt = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				if (fin_go) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = (state_q == FSM_IDLE);
		rd_en      = (state_q == FSM_SCAN) && (rd_idx_q < total_q) && !scan_hit;
		wr_en      = 1'b0;
		wr_addr    = idx_s1;
		wr_data    = rd_data;
		total_nxt  = total_q;
		active_nxt = active_q;
		out_nxt.status        = ST_SWEEP;
		out_nxt.entry_index   = '0;
		out_nxt.expired_count = COUNT_W'(expired_q);

		if (expire) begin
			wr_en          = 1'b1;
			wr_data.active = 1'b0;
		end

		if (state_q == FSM_FINISH) begin
			priority if (req_q.op == OP_SWEEP) begin
				out_nxt.status = ST_SWEEP;
			end else if (own_fin) begin
				out_nxt.status = ST_OWN;
			end else if (hit_q) begin
				out_nxt.status      = ST_UPDATED;
				out_nxt.entry_index = ENTRY_W'(hit_idx_q);
				wr_en               = fin_go;
				wr_addr             = hit_idx_q;
				wr_data             = hit_entry_q;
				wr_data.seen_ms     = req_q.now_ms;
				wr_data.active      = 1'b1;
				if (req_q.is_heartbeat) begin
					wr_data.battery_mv   = req_q.battery_mv;
					wr_data.threat_level = req_q.threat_level;
				end
				if (!hit_entry_q.active) begin
					active_nxt = active_q + CNT_W'(1);
				end
			end else if (full) begin
				out_nxt.status = ST_FULL;
			end else begin
				out_nxt.status       = ST_ADDED;
				out_nxt.entry_index  = ENTRY_W'(total_q[IDX_W-1:0]);
				wr_en                = fin_go;
				wr_addr              = total_q[IDX_W-1:0];
				wr_data.address      = req_q.sender_address;
				wr_data.seen_ms      = req_q.now_ms;
				wr_data.active       = 1'b1;
				wr_data.node         = req_q.sender_node;
				wr_data.battery_mv   = req_q.is_heartbeat ? req_q.battery_mv : 16'd0;
				wr_data.threat_level = req_q.is_heartbeat ? req_q.threat_level : 8'd0;
				total_nxt            = total_q + CNT_W'(1);
				active_nxt           = active_q + CNT_W'(1);
			end
		end

		out_nxt.active_count = COUNT_W'(active_nxt);
		out_nxt.filled_count = COUNT_W'(total_nxt);
		rsp.valid            = out_valid_q;
		rsp.data             = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			rd_idx_q    <= '0;
			total_q     <= '0;
			active_q    <= '0;
			expired_q   <= '0;
			valid_s1    <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			valid_s1 <= rd_en;
			if (accept) begin
				rd_idx_q  <= '0;
				expired_q <= '0;
				hit_q     <= 1'b0;
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (scan_hit) begin
				hit_q <= 1'b1;
			end
			if (expire) begin
				expired_q <= expired_q + CNT_W'(1);
				active_q  <= active_q - CNT_W'(1);
			end
			if (fin_go) begin
				total_q     <= total_nxt;
				active_q    <= active_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.data;
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (scan_hit) begin
			hit_idx_q   <= idx_s1;
			hit_entry_q <= rd_data;
		end
		if (fin_go) begin
			out_q <= out_nxt;
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_ENTRIES))
		else $error("filled count exceeds table size");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= total_q)
		else $error("active count exceeds filled count");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q != FSM_IDLE))
		else $error("entry write while idle");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == FSM_FINISH)
		else $error("response raised outside finish step");

	a_no_read_past_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_idx_q < total_q))
		else $error("read of an unfilled entry");

endmodule

`default_nettype wire
